// ----- sv/lltd_pkg.sv -----
// Shared types and constants of the least-loaded task dispatcher.
package lltd_pkg;

  // Field widths fixed by the item formats
  localparam int WORKER_W = 4;
  localparam int TASK_W   = 3;
  localparam int TRES_W   = 2;
  localparam int STAT_W   = 6;
  localparam int CNT_W    = 3;

  typedef logic signed [STAT_W-1:0] stat_t;

  // Item function codes
  localparam logic FUNC_START  = 1'b0;
  localparam logic FUNC_REPORT = 1'b1;

  // Table codes and limits
  localparam logic [TASK_W-1:0]   NO_TASK      = 3'd7;
  localparam stat_t               STAT_UNFOUND = 6'sb111111;
  localparam stat_t               STAT_MIN     = 6'sb100000;
  localparam logic [CNT_W-1:0]    DONE_MAX     = 3'd7;
  localparam logic [WORKER_W-1:0] NUM_WRK_RST  = 4'd3;

  typedef struct packed {
    logic                func;
    logic [TASK_W-1:0]   task_index;
    logic [WORKER_W-1:0] worker_id;
  } lltd_in_t;

  typedef struct packed {
    logic [WORKER_W-1:0] worker_id_res;
    logic [TRES_W-1:0]   task_index_res;
    logic                stop;
    logic                last;
  } lltd_out_t;

  // Control of the shared selection unit
  typedef struct packed {
    logic clr;
    logic step;
  } lltd_pick_ctl_t;

endpackage

// ----- sv/lltd_chan_if.sv -----
// Valid/ready channel interface with a typed payload.
interface lltd_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ----- sv/lltd_pick.sv -----
// Shared compare unit: finds the unfound task with the fewest workers, one task a cycle.
module lltd_pick #(
  parameter int TIDX_W = 2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lltd_pkg::lltd_pick_ctl_t ctl_i,
  input  logic [TIDX_W-1:0]       idx_i,
  input  lltd_pkg::stat_t         val_i,
  output logic [TIDX_W-1:0]       best_o
);
  import lltd_pkg::*;

  logic [TIDX_W-1:0] best_q;
  stat_t             best_val_q;
  logic              have_q;
  logic              take;

  // Unfound entries are negative; ties go to the later (higher) index
  assign take = ctl_i.step && val_i[STAT_W-1] && (!have_q || (val_i >= best_val_q));

  // Hold the running best, restart on clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q     <= '0;
      best_val_q <= STAT_UNFOUND;
      have_q     <= 1'b0;
    end else if (ctl_i.clr) begin
      best_q     <= '0;
      best_val_q <= STAT_UNFOUND;
      have_q     <= 1'b0;
    end else if (take) begin
      best_q     <= idx_i;
      best_val_q <= val_i;
      have_q     <= 1'b1;
    end
  end

  assign best_o = best_q;

endmodule

// ----- sv/least_loaded_task_dispatcher.sv -----
// Least-loaded task dispatcher: sequencer, task and worker tables, output register.
//
// One item is taken at a time; in_i.ready is high only while the sequencer is
// idle. For each active worker (num_workers, capped at MAX_WORKERS), a start
// item runs the shared compare unit over all NUM_TASKS table entries, one per
// cycle, then writes the result. A report that leaves tasks open first scans
// the worker table for the last worker on the finished task, then reassigns
// each worker on that task the same way and skips the others; the final report
// sends a stop to every active worker; an ignored report yields no result. A
// stalled output holds the sequencer in ST_EMIT. The output register lets a new
// item be accepted while the last result waits.
module least_loaded_task_dispatcher #(
  parameter int NUM_TASKS   = 4,
  parameter int MAX_WORKERS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lltd_chan_if.sink   in_i,
  lltd_chan_if.source out_o,
  lltd_chan_if.sink   cfg_i
);
  import lltd_pkg::*;

  localparam int TIDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int WID_W  = $clog2(MAX_WORKERS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRESCAN,
    ST_WALK,
    ST_PICK,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    MODE_ASSIGN,
    MODE_REASSIGN,
    MODE_STOP
  } mode_e;

  state_e             state_q, state_d;
  mode_e              mode_q, mode_d;
  logic [WID_W-1:0]   w_q, w_d;
  logic [WID_W-1:0]   n_q, n_d;
  logic [WID_W-1:0]   last_w_q, last_w_d;
  logic [TIDX_W-1:0]  t_q, t_d;
  logic [TIDX_W-1:0]  rep_task_q, rep_task_d;
  lltd_out_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic [WORKER_W-1:0] num_workers_q;
  stat_t               status_q [NUM_TASKS];
  logic [TASK_W-1:0]   wtask_q [1:MAX_WORKERS];
  logic [CNT_W-1:0]    done_q;

  lltd_in_t           in_pl;
  logic               in_fire;
  logic               out_free;
  logic [WID_W-1:0]   n_cur;
  logic [TIDX_W-1:0]  rd_idx;
  stat_t              stat_rd;
  logic [TASK_W-1:0]  wt_rd;
  logic               wt_match;
  logic               in_range;
  logic [CNT_W-1:0]   done_inc;
  logic [TIDX_W-1:0]  best;
  lltd_pick_ctl_t     pick_ctl;
  logic               clr_tables;
  logic               rep_wr;
  logic               asg_wr;

  assign in_pl    = in_i.payload;
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;
  assign cfg_i.ready   = 1'b1;

  // Clamp the worker count to the table size
  assign n_cur = (num_workers_q > WORKER_W'(MAX_WORKERS)) ? WID_W'(MAX_WORKERS)
                                                          : num_workers_q[WID_W-1:0];

  assign in_range = in_pl.task_index < TASK_W'(NUM_TASKS);
  assign done_inc = (done_q == DONE_MAX) ? done_q : done_q + 1'b1;

  // Single read port of the task table
  assign stat_rd  = status_q[rd_idx];
  assign wt_rd    = wtask_q[w_q];
  assign wt_match = (wt_rd == TASK_W'(rep_task_q));

  lltd_pick #(
    .TIDX_W (TIDX_W)
  ) u_pick (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (pick_ctl),
    .idx_i  (t_q),
    .val_i  (stat_rd),
    .best_o (best)
  );

  // Sequence one item over workers and tasks
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    w_d         = w_q;
    n_d         = n_q;
    last_w_d    = last_w_q;
    t_d         = t_q;
    rep_task_d  = rep_task_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    rd_idx      = in_pl.task_index[TIDX_W-1:0];
    pick_ctl    = '0;
    clr_tables  = 1'b0;
    rep_wr      = 1'b0;
    asg_wr      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          n_d = n_cur;
          w_d = WID_W'(1);
          if (in_pl.func == FUNC_START) begin
            clr_tables = 1'b1;
            mode_d     = MODE_ASSIGN;
            last_w_d   = n_cur;
            if (n_cur != '0) begin
              state_d = ST_WALK;
            end
          end else if (in_range && stat_rd[STAT_W-1]) begin
            rep_wr     = 1'b1;
            rep_task_d = in_pl.task_index[TIDX_W-1:0];
            last_w_d   = '0;
            if (n_cur != '0) begin
              if (done_inc < CNT_W'(NUM_TASKS)) begin
                mode_d  = MODE_REASSIGN;
                state_d = ST_PRESCAN;
              end else begin
                mode_d   = MODE_STOP;
                last_w_d = n_cur;
                state_d  = ST_WALK;
              end
            end
          end
        end
      end

      // Find the last worker on the finished task
      ST_PRESCAN: begin
        if (wt_match) begin
          last_w_d = w_q;
        end
        if (w_q == n_q) begin
          w_d     = WID_W'(1);
          state_d = (wt_match || (last_w_q != '0)) ? ST_WALK : ST_IDLE;
        end else begin
          w_d = w_q + 1'b1;
        end
      end

      ST_WALK: begin
        case (mode_q)
          MODE_STOP: begin
            state_d = ST_EMIT;
          end
          MODE_ASSIGN: begin
            pick_ctl.clr = 1'b1;
            t_d          = '0;
            state_d      = ST_PICK;
          end
          MODE_REASSIGN: begin
            if (wt_match) begin
              pick_ctl.clr = 1'b1;
              t_d          = '0;
              state_d      = ST_PICK;
            end else begin
              w_d = w_q + 1'b1;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_PICK: begin
        rd_idx        = t_q;
        pick_ctl.step = 1'b1;
        if (t_q == TIDX_W'(NUM_TASKS - 1)) begin
          state_d = ST_EMIT;
        end else begin
          t_d = t_q + 1'b1;
        end
      end

      // Transfer the result into the output register and book the assignment, if not a stop
      ST_EMIT: begin
        rd_idx = best;
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.worker_id_res = WORKER_W'(w_q);
          out_d.last          = (w_q == last_w_q);
          if (mode_q == MODE_STOP) begin
            out_d.task_index_res = '0;
            out_d.stop           = 1'b1;
          end else begin
            out_d.task_index_res = TRES_W'(TASK_W'(best));
            out_d.stop           = 1'b0;
            asg_wr               = 1'b1;
          end
          if (w_q == last_w_q) begin
            state_d = ST_IDLE;
          end else begin
            w_d     = w_q + 1'b1;
            state_d = ST_WALK;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold sequencer state and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_ASSIGN;
      w_q         <= '0;
      n_q         <= '0;
      last_w_q    <= '0;
      t_q         <= '0;
      rep_task_q  <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      w_q         <= w_d;
      n_q         <= n_d;
      last_w_q    <= last_w_d;
      t_q         <= t_d;
      rep_task_q  <= rep_task_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_workers_q <= NUM_WRK_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      num_workers_q <= cfg_i.payload;
    end
  end

  // Update task table, worker table and done count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        status_q[i] <= STAT_UNFOUND;
      end
      for (int i = 1; i <= MAX_WORKERS; i++) begin
        wtask_q[i] <= NO_TASK;
      end
      done_q <= '0;
    end else if (clr_tables) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        status_q[i] <= STAT_UNFOUND;
      end
      for (int i = 1; i <= MAX_WORKERS; i++) begin
        wtask_q[i] <= NO_TASK;
      end
      done_q <= '0;
    end else if (rep_wr) begin
      status_q[rd_idx] <= $signed({{(STAT_W - WORKER_W){1'b0}}, in_pl.worker_id});
      done_q           <= done_inc;
    end else if (asg_wr) begin
      wtask_q[w_q] <= TASK_W'(best);
      if (stat_rd > STAT_MIN) begin
        status_q[rd_idx] <= stat_rd - 1'b1;
      end
    end
  end

endmodule

// ----- sv/lltd_chk.sv -----
// Port-level checker of the dispatcher and its bind to the top level.
module lltd_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input lltd_pkg::lltd_out_t out_payload_i
);
  import lltd_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("result changed while stalled");

  // More results of the same item keep the input closed
  a_busy_until_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_payload_i.last |-> !in_ready_i)
    else $error("input accepted before last result");

  // Stop messages carry no task
  a_stop_task: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_payload_i.stop |-> out_payload_i.task_index_res == '0)
    else $error("stop with task index");

  // Workers are numbered from one
  a_worker_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_payload_i.worker_id_res != '0)
    else $error("result addressed to worker zero");

endmodule

bind least_loaded_task_dispatcher lltd_chk u_lltd_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);
